[rtl/core/fjd_pkg.sv]
package fjd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_DETECT_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_PERIOD_STEPS    = 3'd1;
    localparam logic [2:0] CFG_MIN_PULSES      = 3'd2;
    localparam logic [2:0] CFG_ALERT_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_DEADBAND        = 3'd4;
    localparam logic [2:0] CFG_NOISE_LIMIT     = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // input item tdata layout
    localparam int IN_ENC_A    = 0;
    localparam int IN_ENC_B    = 1;
    localparam int IN_STEPS_LO = 2;
    localparam int IN_STEPS_HI = 33;
    localparam int IN_PRINTING = 34;
    localparam int IN_PWR_LOST = 35;
    localparam int IN_DATA_W   = 40;

    // result item tdata layout
    localparam int OUT_JAM       = 0;
    localparam int OUT_CLOSED    = 1;
    localparam int OUT_PULSES_LO = 2;
    localparam int OUT_PULSES_HI = 18;
    localparam int OUT_BAD_LO    = 19;
    localparam int OUT_BAD_HI    = 21;
    localparam int OUT_DATA_W    = 24;

    localparam int PULSE_W   = 17;
    localparam int PULSE_MAX = 65535;
    localparam int PULSE_MIN = -65536;

    // next pin state when the wheel turns forwards (pins = a | b<<1)
    function automatic logic [1:0] next_fwd(input logic [1:0] pins);
        logic [1:0] res;
        case (pins)
            2'd0:    res = 2'd2;
            2'd1:    res = 2'd0;
            2'd2:    res = 2'd3;
            2'd3:    res = 2'd1;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/filament_jam_detector.sv]
// Filament jam detector. Each input item is either an encoder pin sample
// (s_tuser = 0) or an extruder position check (s_tuser = 1), and gives exactly
// one result item. Samples drive saturating forward/backward wheel counts;
// a check that, while detection is enabled and no closed period is pending, finds
// the extruder more than period_steps past the last closed period closes a
// period, filters the counts into a pulse total and, while printing without
// power loss, judges it against min_pulses. alert_threshold consecutive bad
// periods give a one-item jam pulse. The block takes one item per clock while
// the result side is not stalled: an item waits in the input register, where
// the count update, fold and judgement are done in a single pass, and then in
// the result register. Configuration must be written while no item is in flight.
module filament_jam_detector #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [fjd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fjd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // enc_a, enc_b, extruder_steps[31:0], printing, power_lost, zero pad
    input  logic [fjd_pkg::IN_DATA_W-1:0]       s_tdata,
    // req_type
    input  logic                                s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // jam_detected, period_closed, period_pulses[16:0], bad_periods[2:0], zero pad
    output logic [fjd_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int CW = COUNT_WIDTH;
    localparam int EW = (CW + 2 > 18) ? CW + 2 : 18;
    localparam logic signed [EW-1:0] PMAX = EW'(fjd_pkg::PULSE_MAX);
    localparam logic signed [EW-1:0] PMIN = EW'(fjd_pkg::PULSE_MIN);

    // configuration
    logic        detect_enable_reg;
    logic [15:0] period_steps_reg;
    logic [7:0]  min_pulses_reg;
    logic [2:0]  alert_threshold_reg;
    logic [7:0]  deadband_reg;
    logic [7:0]  noise_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_enable_reg   <= 1'b0;
            period_steps_reg    <= 16'd576;
            min_pulses_reg      <= 8'd1;
            alert_threshold_reg <= 3'd2;
            deadband_reg        <= 8'd2;
            noise_limit_reg     <= 8'd4;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fjd_pkg::CFG_DETECT_ENABLE:   detect_enable_reg   <= cfg_wdata[0];
                fjd_pkg::CFG_PERIOD_STEPS:    period_steps_reg    <= cfg_wdata;
                fjd_pkg::CFG_MIN_PULSES:      min_pulses_reg      <= cfg_wdata[7:0];
                fjd_pkg::CFG_ALERT_THRESHOLD: alert_threshold_reg <= cfg_wdata[2:0];
                fjd_pkg::CFG_DEADBAND:        deadband_reg        <= cfg_wdata[7:0];
                fjd_pkg::CFG_NOISE_LIMIT:     noise_limit_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input register
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [1:0]  in_pins_reg;
    logic [31:0] in_pos_reg;
    logic        in_printing_reg;
    logic        in_lost_reg;

    logic m_valid_reg;
    logic [fjd_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic m_data_next;
    logic advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg     <= s_tuser;
            in_pins_reg     <= {s_tdata[fjd_pkg::IN_ENC_B], s_tdata[fjd_pkg::IN_ENC_A]};
            in_pos_reg      <= s_tdata[fjd_pkg::IN_STEPS_HI:fjd_pkg::IN_STEPS_LO];
            in_printing_reg <= s_tdata[fjd_pkg::IN_PRINTING];
            in_lost_reg     <= s_tdata[fjd_pkg::IN_PWR_LOST];
        end
    end

    // detector state
    logic [1:0]                  last_pins_reg, last_pins_next;
    logic [CW-1:0]               fwd_reg, fwd_next;
    logic [CW-1:0]               bwd_reg, bwd_next;
    logic signed [16:0]          saved_reg, saved_next;
    logic [31:0]                 last_steps_reg, last_steps_next;
    logic                        pending_reg, pending_next;
    logic [2:0]                  bad_reg, bad_next;

    logic                        jam;
    logic                        closed;
    logic signed [16:0]          total;

    logic [31:0]                 du;
    logic                        past_period;
    logic [CW-1:0]               absd;
    logic signed [EW-1:0]        f_s, b_s, tot_raw, tot_clamp;
    logic                        pend_mid;
    logic signed [16:0]          saved_mid;
    logic [2:0]                  lim;

    assign du          = in_pos_reg - last_steps_reg;
    assign past_period = $signed({du[31], du}) > $signed({17'd0, period_steps_reg});

    // fold of the wheel counts into one signed total
    always_comb begin
        absd = (fwd_reg >= bwd_reg) ? fwd_reg - bwd_reg : bwd_reg - fwd_reg;
        f_s  = $signed(EW'(fwd_reg));
        b_s  = $signed(EW'(bwd_reg));
        if (absd < CW'(deadband_reg)) begin
            tot_raw = '0;
        end else if (bwd_reg < CW'(noise_limit_reg) && bwd_reg < fwd_reg) begin
            tot_raw = f_s + b_s;
        end else if (bwd_reg > fwd_reg && fwd_reg < CW'(noise_limit_reg)) begin
            tot_raw = f_s - b_s;
        end else begin
            tot_raw = f_s;
        end
        if (tot_raw > PMAX) begin
            tot_clamp = PMAX;
        end else if (tot_raw < PMIN) begin
            tot_clamp = PMIN;
        end else begin
            tot_clamp = tot_raw;
        end
    end

    assign lim = (alert_threshold_reg == 3'd0) ? 3'd0 : alert_threshold_reg - 3'd1;

    always_comb begin
        last_pins_next  = last_pins_reg;
        fwd_next        = fwd_reg;
        bwd_next        = bwd_reg;
        saved_next      = saved_reg;
        last_steps_next = last_steps_reg;
        pending_next    = pending_reg;
        bad_next        = bad_reg;
        jam             = 1'b0;
        closed          = 1'b0;
        total           = '0;
        pend_mid        = pending_reg;
        saved_mid       = saved_reg;

        if (!in_type_reg) begin
            if (in_pins_reg != last_pins_reg) begin
                if (fjd_pkg::next_fwd(last_pins_reg) == in_pins_reg) begin
                    fwd_next = (fwd_reg == '1) ? fwd_reg : fwd_reg + 1'b1;
                end else if (fjd_pkg::next_fwd(in_pins_reg) == last_pins_reg) begin
                    bwd_next = (bwd_reg == '1) ? bwd_reg : bwd_reg + 1'b1;
                end
            end
            last_pins_next = in_pins_reg;
        end else begin
            if (detect_enable_reg && !pending_reg && past_period) begin
                closed          = 1'b1;
                last_steps_next = in_pos_reg;
                pend_mid        = 1'b1;
                total           = tot_clamp[16:0];
                if (tot_clamp != '0) begin
                    saved_mid = tot_clamp[16:0];
                    fwd_next  = '0;
                    bwd_next  = '0;
                end
            end
            pending_next = pend_mid;
            saved_next   = saved_mid;
            if (!in_lost_reg && in_printing_reg && pend_mid) begin
                if (saved_mid < $signed({9'd0, min_pulses_reg})) begin
                    if (bad_reg >= lim) begin
                        jam      = 1'b1;
                        bad_next = 3'd0;
                    end else begin
                        bad_next = bad_reg + 3'd1;
                    end
                end else begin
                    bad_next = 3'd0;
                end
                pending_next = 1'b0;
                saved_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg  <= '0;
            fwd_reg        <= '0;
            bwd_reg        <= '0;
            saved_reg      <= '0;
            last_steps_reg <= '0;
            pending_reg    <= 1'b0;
            bad_reg        <= '0;
        end else if (advance) begin
            last_pins_reg  <= last_pins_next;
            fwd_reg        <= fwd_next;
            bwd_reg        <= bwd_next;
            saved_reg      <= saved_next;
            last_steps_reg <= last_steps_next;
            pending_reg    <= pending_next;
            bad_reg        <= bad_next;
        end
    end

    // result register
    assign m_data_next = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_data_next) begin
            m_data_reg <= {2'b00, bad_next, total, closed, jam};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/core/fjd_checker.sv]
module fjd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fjd_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a jam clears the run of bad periods
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[fjd_pkg::OUT_JAM]
        |-> m_tdata[fjd_pkg::OUT_BAD_HI:fjd_pkg::OUT_BAD_LO] == 3'd0)
        else $error("jam with nonzero bad period count");

    // pulse total only on a closing item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[fjd_pkg::OUT_CLOSED]
        |-> m_tdata[fjd_pkg::OUT_PULSES_HI:fjd_pkg::OUT_PULSES_LO] == '0)
        else $error("pulse total without a closed period");

endmodule

bind filament_jam_detector fjd_checker u_fjd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
